### rtl/hbmmc_pkg.sv
// Package with the types, constants and helpers of the H-bridge motor mode controller.
package hbmmc_pkg;

    // Field widths
    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned S_DATA_W = 40;  // 35 bits of fields, padded to whole bytes
    localparam int unsigned M_DATA_W = 56;  // 51 bits of fields, padded to whole bytes
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    // Register reset values
    localparam logic signed [SPEED_W-1:0] MAX_SPEED_RST = 16'sd10000;
    localparam logic signed [SPEED_W-1:0] MIN_SPEED_RST = -16'sd10000;

    // Register indexes (taken from address bit 2)
    typedef enum logic {
        REG_MAX_SPEED = 1'b0,
        REG_MIN_SPEED = 1'b1
    } reg_idx_t;

    // Command codes; the two unused codes behave as no command
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SLEEP = 3'd3,
        CMD_WAKE  = 3'd4,
        CMD_BRAKE = 3'd5
    } cmd_t;

    // Motor modes
    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED  = 3'd0,
        MODE_RUNNING  = 3'd1,
        MODE_SLEEPING = 3'd2,
        MODE_NSTOP    = 3'd3,
        MODE_FSTOP    = 3'd4
    } mode_t;

    // Clamp a speed: the upper limit is tested first, then the lower one.
    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SPEED_W-1:0] v,
        input logic signed [SPEED_W-1:0] max_v,
        input logic signed [SPEED_W-1:0] min_v
    );
        logic signed [SPEED_W-1:0] r;
        if (v > max_v) begin
            r = max_v;
        end else if (v < min_v) begin
            r = min_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/hbridge_motor_mode_controller_core.sv
// H-bridge motor mode controller: command decoding, speed clamping, mode and PWM duty update.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | command, requested speed, encoder_count
//  m_       | out       | m_tvalid/m_tready  | pwm_a, pwm_b, mode, measured_speed
//  apb      | in/out    | psel/penable/pready| max_speed @0x0, min_speed @0x4
//
// One transaction per clock cycle is sustained while m_tready is high; a tick passes
// through the input register and then waits in the result register.
// The mode, duty and speed cache update as a tick moves from the input register into
// the result register, so the next tick sees them in the following cycle.
// A stalled result register holds the input register, which still accepts while empty.
// Reset is synchronous to aclk, active low, and needs no further clearing cycles.
module hbridge_motor_mode_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] command, [18:3] requested speed, [34:19] encoder_count, [39:35] zero
    input  logic [hbmmc_pkg::S_DATA_W-1:0]    s_tdata,
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] pwm_a, [31:16] pwm_b, [34:32] mode, [50:35] measured_speed, [55:51] zero
    output logic [hbmmc_pkg::M_DATA_W-1:0]    m_tdata,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hbmmc_pkg::APB_AW-1:0]      paddr,
    input  logic [hbmmc_pkg::APB_DW-1:0]      pwdata,
    output logic [hbmmc_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);
    import hbmmc_pkg::*;

    // Configuration registers
    logic signed [SPEED_W-1:0] max_speed_reg;
    logic signed [SPEED_W-1:0] min_speed_reg;
    logic                      cfg_write;
    reg_idx_t                  cfg_idx;

    // Input register
    logic                s1_valid_reg;
    logic [S_DATA_W-1:0] s1_data_reg;

    // Controller state
    mode_t                     mode_reg;
    mode_t                     mode_next;
    mode_t                     mode_cmd;
    logic [SPEED_W-1:0]        duty_reg;
    logic [SPEED_W-1:0]        duty_next;
    logic signed [SPEED_W-1:0] speed_cache_reg;

    // Result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // Datapath signals
    logic                      advance;
    logic                      out_load;
    cmd_t                      cmd;
    logic signed [SPEED_W-1:0] target_c;
    logic signed [SPEED_W-1:0] sample_c;
    logic [SPEED_W-1:0]        target_mag;
    logic                      target_pos;
    logic [SPEED_W-1:0]        pwm_a;
    logic [SPEED_W-1:0]        pwm_b;

    // Configuration access: the register index comes from address bit 2.
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_MAX_SPEED: prdata = APB_DW'(max_speed_reg);
            REG_MIN_SPEED: prdata = APB_DW'(min_speed_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= MAX_SPEED_RST;
            min_speed_reg <= MIN_SPEED_RST;
        end else if (cfg_write) begin
            if (cfg_idx == REG_MAX_SPEED) begin
                max_speed_reg <= pwdata[SPEED_W-1:0];
            end else begin
                min_speed_reg <= pwdata[SPEED_W-1:0];
            end
        end
    end

    // Handshake: the result register loads when empty or being taken.
    assign out_load = !m_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_load;
    assign s_tready = !s1_valid_reg || out_load;

    // Field extraction and clamping of the registered tick.
    assign cmd        = cmd_t'(s1_data_reg[CMD_W-1:0]);
    assign target_c   = clamp_speed(s1_data_reg[CMD_W +: SPEED_W], max_speed_reg,
                                    min_speed_reg);
    assign sample_c   = clamp_speed(s1_data_reg[CMD_W+SPEED_W +: SPEED_W], max_speed_reg,
                                    min_speed_reg);
    assign target_pos = !target_c[SPEED_W-1] && (target_c != '0);
    // Two's complement negation also gives the right magnitude for the most negative value.
    assign target_mag = target_c[SPEED_W-1] ? SPEED_W'(~target_c + 1'b1)
                                            : SPEED_W'(target_c);

    // Command stage of the mode update.
    always_comb begin
        mode_cmd = mode_reg;
        unique case (cmd)
            CMD_START: if (mode_reg == MODE_STOPPED) mode_cmd = MODE_RUNNING;
            CMD_STOP:  begin
                if (mode_reg == MODE_RUNNING || mode_reg == MODE_SLEEPING) begin
                    mode_cmd = MODE_NSTOP;
                end
            end
            CMD_SLEEP: if (mode_reg == MODE_RUNNING) mode_cmd = MODE_SLEEPING;
            CMD_WAKE:  if (mode_reg == MODE_SLEEPING) mode_cmd = MODE_RUNNING;
            CMD_BRAKE: mode_cmd = MODE_FSTOP;
            default:   mode_cmd = mode_reg;
        endcase
    end

    // Duty and mode after the tick; normal stopping tests the speed cached last tick.
    always_comb begin
        mode_next = mode_cmd;
        duty_next = duty_reg;
        unique case (mode_cmd)
            MODE_RUNNING:  duty_next = target_mag;
            MODE_SLEEPING: duty_next = duty_reg;
            MODE_NSTOP: begin
                duty_next = '0;
                if (speed_cache_reg == '0) mode_next = MODE_STOPPED;
            end
            MODE_FSTOP: begin
                duty_next = '0;
                mode_next = MODE_STOPPED;
            end
            default:       duty_next = '0;
        endcase
    end

    // Steering of the duty to one side of the bridge.
    assign pwm_a = target_pos ? duty_next : '0;
    assign pwm_b = target_pos ? '0 : duty_next;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_data_reg <= s_tdata;
        end
    end

    // Controller state, updated as a tick moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_STOPPED;
            duty_reg        <= '0;
            speed_cache_reg <= '0;
        end else if (advance) begin
            mode_reg        <= mode_next;
            duty_reg        <= duty_next;
            speed_cache_reg <= sample_c;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {5'b0, sample_c, mode_next, pwm_b, pwm_a};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // Only one side of the bridge is ever driven.
    assert_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] == '0) || (m_tdata[31:16] == '0))
        else $error("both bridge channels driven");

    // Force stopping always settles to stopped within the same tick.
    assert_no_fstop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:32] != MODE_FSTOP))
        else $error("force stopping mode reported");

    // An empty result register never holds back the input side.
    assert_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Controller state changes only when a tick moves into the result register.
    assert_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(mode_reg) && $stable(duty_reg))
        else $error("controller state changed without a tick");
`endif

endmodule

### bench/tb_hbridge_motor_mode_controller_core.sv
// Self-checking testbench for the H-bridge motor mode controller core.
module tb_hbridge_motor_mode_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hbmmc_pkg::*;

    // The two spare command codes, which the block must treat as no command.
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
    localparam int unsigned      LONG_HOLD  = 60;
    localparam int unsigned      PHASE_TICKS = 250;

    // One result transaction split into its fields.
    typedef struct {
        logic [SPEED_W-1:0] pwm_a;
        logic [SPEED_W-1:0] pwm_b;
        logic [MODE_W-1:0]  mode;
        logic [SPEED_W-1:0] speed;
    } tick_result_t;

    // Scoreboard: a behavioural copy of the controller plus the queue of expected results.
    class mode_ctrl_scoreboard;
        logic signed [SPEED_W-1:0] max_lim;
        logic signed [SPEED_W-1:0] min_lim;
        mode_t                     mode_q;
        logic        [SPEED_W-1:0] duty_q;
        logic signed [SPEED_W-1:0] speed_q;
        tick_result_t              expected_q[$];
        int                        mismatches;

        function new();
            max_lim    = MAX_SPEED_RST;
            min_lim    = MIN_SPEED_RST;
            mode_q     = MODE_STOPPED;
            duty_q     = '0;
            speed_q    = '0;
            mismatches = 0;
        endfunction

        function void set_limit(reg_idx_t idx, logic signed [SPEED_W-1:0] v);
            case (idx)
                REG_MAX_SPEED: max_lim = v;
                REG_MIN_SPEED: min_lim = v;
                default: ;
            endcase
        endfunction

        // With crossed limits, values above the upper limit take it and all others take the lower one.
        function logic signed [SPEED_W-1:0] limit_speed(logic signed [SPEED_W-1:0] v);
            if (v > max_lim) begin
                return max_lim;
            end else if (v < min_lim) begin
                return min_lim;
            end
            return v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_mismatch(string msg);
            if (mismatches < 10) begin
                $display("%s", msg);
            end
            mismatches++;
        endfunction

        // Works out the result of one accepted tick and updates the copy of the state.
        function void note_tick(logic [S_DATA_W-1:0] d);
            logic [CMD_W-1:0]          cmd;
            logic signed [SPEED_W-1:0] tgt;
            logic signed [SPEED_W-1:0] smp;
            tick_result_t              res;
            cmd = d[2:0];
            tgt = limit_speed(d[18:3]);
            smp = limit_speed(d[34:19]);

            // The command acts first, and only where it applies to the current mode.
            case (cmd)
                CMD_START: begin
                    if (mode_q == MODE_STOPPED) mode_q = MODE_RUNNING;
                end
                CMD_STOP: begin
                    if (mode_q == MODE_RUNNING || mode_q == MODE_SLEEPING) mode_q = MODE_NSTOP;
                end
                CMD_SLEEP: begin
                    if (mode_q == MODE_RUNNING) mode_q = MODE_SLEEPING;
                end
                CMD_WAKE: begin
                    if (mode_q == MODE_SLEEPING) mode_q = MODE_RUNNING;
                end
                CMD_BRAKE: begin
                    mode_q = MODE_FSTOP;
                end
                default: ;
            endcase

            // Duty and mode update; a normal stop looks at the speed of the previous tick.
            case (mode_q)
                MODE_RUNNING: begin
                    duty_q = (tgt > 0) ? tgt : -tgt;
                end
                MODE_SLEEPING: ;
                MODE_NSTOP: begin
                    duty_q = '0;
                    if (speed_q == 0) mode_q = MODE_STOPPED;
                end
                MODE_FSTOP: begin
                    duty_q = '0;
                    mode_q = MODE_STOPPED;
                end
                default: begin
                    duty_q = '0;
                end
            endcase

            speed_q   = smp;
            res.pwm_a = (tgt > 0) ? duty_q : '0;
            res.pwm_b = (tgt > 0) ? '0 : duty_q;
            res.mode  = mode_q;
            res.speed = smp;
            expected_q.push_back(res);
        endfunction

        // Compares one result transaction with the oldest expectation.
        function void check_result(logic [M_DATA_W-1:0] d);
            tick_result_t got;
            tick_result_t want;
            got.pwm_a = d[15:0];
            got.pwm_b = d[31:16];
            got.mode  = d[34:32];
            got.speed = d[50:35];
            if (expected_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result: pwm_a %0d pwm_b %0d mode %0d speed %0d",
                                        got.pwm_a, got.pwm_b, got.mode, $signed(got.speed)));
                return;
            end
            want = expected_q.pop_front();
            if (got.pwm_a !== want.pwm_a || got.pwm_b !== want.pwm_b ||
                got.mode !== want.mode || got.speed !== want.speed) begin
                note_mismatch($sformatf(
                    "mismatch: pwm_a %0d/%0d pwm_b %0d/%0d mode %0d/%0d speed %0d/%0d (exp/got)",
                    want.pwm_a, got.pwm_a, want.pwm_b, got.pwm_b, want.mode, got.mode,
                    $signed(want.speed), $signed(got.speed)));
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // [2:0] command, [18:3] requested speed, [34:19] encoder_count, [39:35] zero
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // [15:0] pwm_a, [31:16] pwm_b, [34:32] mode, [50:35] measured_speed, [55:51] zero
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    bit                    idle_en      = 1'b1;
    bit                    hold_request = 1'b0;
    mode_ctrl_scoreboard   tick_board   = new();

    hbridge_motor_mode_controller_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog for a hung run.
    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    // Transaction monitor on both channels, sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) tick_board.note_tick(s_tdata);
            if (m_tvalid && m_tready) tick_board.check_result(m_tdata);
        end
    end

    // Result sink: random short stalls, and one long hold when requested.
    initial begin : result_sink
        int gap;
        int hold;
        gap      = 0;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 3) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one tick, after an optional idle burst, and waits until it is taken.
    task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic [SPEED_W-1:0] tgt,
                             input logic [SPEED_W-1:0] enc);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, enc, tgt, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random tick, weighted towards meaningful commands and zero speed samples.
    task automatic send_random_tick();
        int                 r;
        logic [CMD_W-1:0]   cmd;
        logic [SPEED_W-1:0] tgt;
        logic [SPEED_W-1:0] enc;
        r = $urandom_range(0, 99);
        if (r < 30)      cmd = CMD_NONE;
        else if (r < 45) cmd = CMD_START;
        else if (r < 57) cmd = CMD_STOP;
        else if (r < 67) cmd = CMD_SLEEP;
        else if (r < 77) cmd = CMD_WAKE;
        else if (r < 84) cmd = CMD_BRAKE;
        else if (r < 89) cmd = CMD_SPARE6;
        else if (r < 93) cmd = CMD_SPARE7;
        else             cmd = CMD_W'($urandom_range(0, 7));

        case ($urandom_range(0, 9))
            0:       tgt = 16'h7FFF;
            1:       tgt = 16'h8000;
            2:       tgt = '0;
            3, 4, 5: tgt = 16'($urandom_range(0, 24000) - 12000);
            default: tgt = 16'($urandom());
        endcase

        case ($urandom_range(0, 3))
            0:       enc = '0;
            1:       enc = 16'($urandom_range(0, 400) - 200);
            default: enc = 16'($urandom());
        endcase
        send_tick(cmd, tgt, enc);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tick_board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input reg_idx_t idx, input logic signed [SPEED_W-1:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW - SPEED_W){v[SPEED_W-1]}}, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tick_board.set_limit(idx, v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(input logic signed [SPEED_W-1:0] hi,
                              input logic signed [SPEED_W-1:0] lo);
        wait_drained();
        write_reg(REG_MAX_SPEED, hi);
        write_reg(REG_MIN_SPEED, lo);
    endtask

    // Main stimulus sequence.
    initial begin : stimulus
        logic signed [SPEED_W-1:0] hi;
        logic signed [SPEED_W-1:0] lo;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed ticks with the reset limits: every command, held duty while
        // sleeping, a normal stop that waits for the previous speed to be zero.
        send_tick(CMD_NONE,   16'sd0,     16'sd0);
        send_tick(CMD_START,  16'h7FFF,   16'h8000);
        send_tick(CMD_SLEEP,  -16'sd5,    16'sd123);
        send_tick(CMD_WAKE,   16'h8000,   16'sd500);
        send_tick(CMD_STOP,   16'sd100,   16'sd0);
        send_tick(CMD_NONE,   16'sd100,   16'sd0);
        send_tick(CMD_START,  16'sd0,     16'sd7);
        send_tick(CMD_SPARE6, 16'sd1,     -16'sd1);
        send_tick(CMD_SPARE7, -16'sd1,    16'sd0);
        send_tick(CMD_WAKE,   16'sd20000, 16'sd0);
        send_tick(CMD_SLEEP,  16'sd300,   16'sd0);
        send_tick(CMD_STOP,   16'sd300,   16'sd0);
        send_tick(CMD_STOP,   16'sd50,    16'sd0);
        send_tick(CMD_SLEEP,  16'sd50,    16'sd0);
        send_tick(CMD_START,  16'sd50,    16'sd9);
        send_tick(CMD_BRAKE,  16'sd50,    16'sd0);

        // Widest limits: the most negative target gives the largest duty.
        set_limits(16'sh7FFF, 16'sh8000);
        send_tick(CMD_START, 16'h8000, 16'h7FFF);
        send_tick(CMD_NONE,  16'h7FFF, 16'h8000);
        send_tick(CMD_STOP,  16'sd1,   16'sd0);
        send_tick(CMD_BRAKE, 16'sd1,   16'sd0);

        // Crossed limits: values above the maximum take the maximum.
        set_limits(-16'sd100, 16'sd100);
        send_tick(CMD_START, 16'sd200, 16'h8000);
        send_tick(CMD_NONE,  16'sd50,  16'h7FFF);

        // Random phases, each with its own pair of limits.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin hi = 16'sd10000;  lo = -16'sd10000; end
                1: begin hi = 16'sh7FFF;   lo = 16'sh8000;   end
                2: begin hi = 16'sd0;      lo = 16'sd0;      end
                3: begin hi = -16'sd100;   lo = 16'sd100;    end
                4: begin hi = 16'($urandom()); lo = 16'($urandom()); end
                default: begin hi = 16'sd12000; lo = -16'sd3000; end
            endcase
            set_limits(hi, lo);
            // The last phase runs without any idling on either side.
            if (ph == 5) idle_en = 1'b0;
            // Early on, the sink holds off for a long stretch while ticks keep coming.
            if (ph == 1) hold_request = 1'b1;
            repeat (PHASE_TICKS) send_random_tick();
        end

        wait_drained();
        if (tick_board.mismatches == 0 && tick_board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
